// ===== sv/hgnm_pkg.sv =====
`timescale 1ns / 1ps

package hgnm_pkg;

   localparam int GRID_SIZE_DEFAULT = 64;
   localparam int HEIGHT_W          = 16;
   localparam int POS_W             = 6;
   localparam int NORM_W            = 16;
   localparam int NORM_Z_W          = 15;
   localparam int FRAC_BITS         = 14;
   localparam int QUOT_W            = 15;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic                       frame_start;
   } req_type;

   typedef struct packed {
      logic        [POS_W-1:0]    pos_x;
      logic        [POS_W-1:0]    pos_y;
      logic signed [NORM_W-1:0]   normal_x;
      logic signed [NORM_W-1:0]   normal_y;
      logic        [NORM_Z_W-1:0] normal_z;
      logic                       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEFT,
      ST_ABOVE,
      ST_RIGHT,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ===== sv/height_grid_normal_map_core.sv =====
`timescale 1ns / 1ps

// Height grid to normal map. Takes a GRID_SIZE x GRID_SIZE grid of signed
// Q4.12 heights in raster order (column fastest; frame_start restarts the
// position at (0,0)) and, for every interior pixel, returns the unit normal
// of the central-difference gradient scaled by GRID_SIZE/4 as Q1.14 (x and
// y signed, z unsigned), pixel position and last flag on the final interior
// pixel. The normal of pixel (x-1, y-1) is formed when sample (x, y) arrives.
// The two previous rows live in one single-port-read line memory of
// GRID_SIZE entries, each holding the row above and the row two above; the
// first two rows of a grid after reset must be complete before any normal is
// meaningful. A sample that yields no normal passes only the idle and left
// states (read-modify-write of the line memory). A sample that yields a normal
// also takes three serial memory reads, two squaring steps, a bit-pair square
// root of the SW = 2*(16 + clog2(GRID_SIZE)) + 2 bit sum of squares and three
// 15-bit restoring divisions, run on one shared divider. A finished normal
// sits in an output register, so the next word is taken while it waits to be
// read.

module height_grid_normal_map_core #(
   parameter int GRID_SIZE = hgnm_pkg::GRID_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hgnm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hgnm_pkg::rsp_type rsp_data
);
   import hgnm_pkg::*;

   localparam int CW = $clog2(GRID_SIZE);            // column/row counter
   localparam int MW = HEIGHT_W + $clog2(GRID_SIZE);  // gradient magnitude
   localparam int SW = 2 * MW + 2;                    // sum of squares
   localparam int RW = MW + 1;                        // square root
   localparam int NW = MW + FRAC_BITS + 1;            // dividend
   localparam int EW = 2 * HEIGHT_W;                  // line memory entry

   localparam logic [CW-1:0] LAST_POS = CW'(GRID_SIZE - 1);
   localparam logic signed [MW:0] GRID_S = (MW+1)'(GRID_SIZE);
   localparam logic [MW-1:0] UNIT_MAG = MW'(1) << FRAC_BITS;
   localparam logic [SW-1:0] UNIT_SQ  = SW'(1) << (2 * FRAC_BITS);
   localparam logic [SW-1:0] ROOT_BIT0 = SW'(1) << (SW - 2);

   // line memory: [HEIGHT_W-1:0] row above, [EW-1:HEIGHT_W] row two above
   logic [EW-1:0] line_mem [GRID_SIZE];
   logic [EW-1:0] rd_ff;
   logic [CW-1:0] rd_addr;
   logic          wr_en;

   state_type state_ff, state_in;

   logic [CW-1:0] col_ff, row_ff;
   logic [HEIGHT_W-1:0] dly0_ff, dly1_ff;

   logic [CW-1:0] x_ff, y_ff, wi_ff;
   logic [HEIGHT_W-1:0] below_ff, new_prev_ff;
   logic emit_ff;
   logic signed [HEIGHT_W-1:0] left_ff, above_ff;
   logic signed [MW:0] ax_ff, ay_ff;
   logic [2*MW-1:0] sq_ff;
   logic [SW-1:0] s_ff, res_ff, bit_ff;
   logic [1:0] comp_ff;
   logic [RW-1:0] rem_ff;
   logic [FRAC_BITS:0] num_ff;
   logic [QUOT_W-2:0] q_ff;
   logic [3:0] cnt_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff;
   logic [NORM_Z_W-1:0] nz_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [CW-1:0] x_cur, y_cur, wi_cur, xm1;
   logic [MW-1:0] magx, magy, mag_sel;
   logic [2*MW-1:0] sqy;
   logic [RW-1:0] len;
   logic [SW-1:0] trial;
   logic [NW-1:0] num_full;
   logic [RW:0] div_t;
   logic div_ge;
   logic [QUOT_W-1:0] quot;
   logic signed [NORM_W-1:0] quot_s;
   logic out_free;
   logic signed [HEIGHT_W:0] dx, dy;

   // position of the incoming word
   always_comb begin
      x_cur  = req_data.frame_start ? '0 : col_ff;
      y_cur  = req_data.frame_start ? '0 : row_ff;
      wi_cur = (x_cur >= CW'(2)) ? x_cur - CW'(2) : x_cur + CW'(GRID_SIZE - 2);
      xm1    = (x_ff >= CW'(1)) ? x_ff - CW'(1) : LAST_POS;
   end

   // datapath helpers
   always_comb begin
      dx = $signed(rd_ff[HEIGHT_W-1:0]) - left_ff;
      dy = $signed(below_ff) - above_ff;
      magx = ax_ff[MW] ? MW'(-ax_ff) : MW'(ax_ff);
      magy = ay_ff[MW] ? MW'(-ay_ff) : MW'(ay_ff);
      sqy = magy * magy;
      len = res_ff[RW-1:0];
      trial = res_ff + bit_ff;
      case (comp_ff)
         2'd0:    mag_sel = magx;
         2'd1:    mag_sel = magy;
         default: mag_sel = UNIT_MAG;
      endcase
      num_full = {mag_sel, FRAC_BITS'(0)} + NW'(len >> 1);
      div_t = {rem_ff, num_ff[FRAC_BITS]};
      div_ge = div_t >= {1'b0, len};
      quot = {q_ff, div_ge};
      quot_s = NORM_W'(quot);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LEFT;
         ST_LEFT:  state_in = emit_ff ? ST_ABOVE : ST_IDLE;
         ST_ABOVE: state_in = ST_RIGHT;
         ST_RIGHT: state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_ROOT;
         ST_ROOT:  if (bit_ff == SW'(1)) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 4'(QUOT_W - 1))
               state_in = (comp_ff == 2'd2) ? ST_OUT : ST_LOAD;
         end
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      rd_addr   = x_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = wi_cur;
         end
         ST_LEFT: begin
            wr_en   = 1'b1;
            rd_addr = xm1;
         end
         default: rd_addr = x_ff;
      endcase
   end

   // line memory
   always_ff @(posedge clock) begin
      if (wr_en) line_mem[wi_ff] <= {rd_ff[HEIGHT_W-1:0], new_prev_ff};
      rd_ff <= line_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         dly0_ff      <= '0;
         dly1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_valid && req_ready) begin
            dly0_ff <= req_data.height;
            dly1_ff <= dly0_ff;
            if (x_cur == LAST_POS) begin
               col_ff <= '0;
               row_ff <= (y_cur == LAST_POS) ? '0 : y_cur + CW'(1);
            end else begin
               col_ff <= x_cur + CW'(1);
               row_ff <= y_cur;
            end
         end
         if (state_ff == ST_OUT && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff        <= x_cur;
            y_ff        <= y_cur;
            wi_ff       <= wi_cur;
            below_ff    <= dly0_ff;
            new_prev_ff <= dly1_ff;
            emit_ff     <= (x_cur >= CW'(2)) && (y_cur >= CW'(2));
         end
         ST_LEFT:  left_ff  <= $signed(rd_ff[HEIGHT_W-1:0]);
         ST_ABOVE: above_ff <= $signed(rd_ff[EW-1:HEIGHT_W]);
         ST_RIGHT: begin
            ax_ff <= -((MW+1)'(dx) * GRID_S);
            ay_ff <= (MW+1)'(dy) * GRID_S;
         end
         ST_SQX: sq_ff <= magx * magx;
         ST_SQY: begin
            s_ff   <= SW'(sq_ff) + SW'(sqy) + UNIT_SQ;
            res_ff <= '0;
            bit_ff <= ROOT_BIT0;
         end
         ST_ROOT: begin
            if (s_ff >= trial) begin
               s_ff   <= s_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            comp_ff <= 2'd0;
         end
         ST_LOAD: begin
            rem_ff <= RW'(num_full[NW-1:QUOT_W]);
            num_ff <= num_full[QUOT_W-1:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= div_ge ? RW'(div_t - {1'b0, len}) : RW'(div_t);
            num_ff <= num_ff << 1;
            q_ff   <= quot[QUOT_W-2:0];
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(QUOT_W - 1)) begin
               comp_ff <= comp_ff + 2'd1;
               case (comp_ff)
                  2'd0:    nx_ff <= ax_ff[MW] ? -quot_s : quot_s;
                  2'd1:    ny_ff <= ay_ff[MW] ? -quot_s : quot_s;
                  default: nz_ff <= quot;
               endcase
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_ff.pos_x    <= POS_W'(x_ff - CW'(1));
               rsp_data_ff.pos_y    <= POS_W'(y_ff - CW'(1));
               rsp_data_ff.normal_x <= nx_ff;
               rsp_data_ff.normal_y <= ny_ff;
               rsp_data_ff.normal_z <= nz_ff;
               rsp_data_ff.last     <= (x_ff == LAST_POS) && (y_ff == LAST_POS);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/hgnm_checker.sv =====
`timescale 1ns / 1ps

module hgnm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hgnm_pkg::rsp_type rsp_data
);
   import hgnm_pkg::*;

   // hold a word until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   // one word in flight: ready drops after a take
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // z component is always positive and at most one
   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.normal_z != '0 && rsp_data.normal_z <= NORM_Z_W'(16384))
      else $error("normal z out of range");

   // the final interior pixel sits on the diagonal
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.pos_x == rsp_data.pos_y)
      else $error("last flag on an off-diagonal pixel");

endmodule

bind height_grid_normal_map_core hgnm_checker u_hgnm_checker (.*);

// ===== test/height_grid_normal_map_core_test.sv =====
`timescale 1ns / 1ps

module height_grid_normal_map_core_test;
   import hgnm_pkg::*;

   localparam int GRID = GRID_SIZE_DEFAULT;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_WORDS = 1020;

   typedef struct {
      logic signed [15:0] height;
      bit                 frame_start;
      int                 count;
      bit                 flat;   // every normal caused by these words is straight up
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Model state: two line buffers, the two-word delay line, the write position.
   logic signed [15:0] line_above[GRID];
   logic signed [15:0] line_above2[GRID];
   logic signed [15:0] delay_line[2];
   int unsigned        col_pos;
   int unsigned        row_pos;

   rsp_type     normal_expected[$];
   req_type     sample_q[$];
   bit          flat_q[$];
   dir_row_type dir_rows[12];
   int          failures;
   int          taken;
   longint      cycles;

   height_grid_normal_map_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale one component to Q1.14 of the unit vector, round half away from zero.
   function automatic longint unit_component(input longint a, input longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (a < 0) ? longint'(-a) : a;
      q = ((mag << 14) + (len >> 1)) / len;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Advance the model by one accepted word; queue the normal it completes.
   task automatic accept_sample(input req_type s, input bit flat);
      int unsigned     cx;
      int unsigned     cy;
      int unsigned     wi;
      longint          ax;
      longint          ay;
      longint          az;
      longint unsigned len;
      rsp_type         r;
      if (s.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      cx = col_pos;
      cy = row_pos;
      if (cx >= 2 && cy >= 2) begin
         ax = -(longint'(line_above[cx]) - longint'(line_above[cx-2])) * GRID;
         ay = (longint'(delay_line[0]) - longint'(line_above2[cx-1])) * GRID;
         az = 16384;
         len = int_sqrt(ax * ax + ay * ay + az * az);
         if (len == 0) len = 1;
         r.pos_x    = 6'(cx - 1);
         r.pos_y    = 6'(cy - 1);
         r.normal_x = 16'(unit_component(ax, len));
         r.normal_y = 16'(unit_component(ay, len));
         r.normal_z = 15'(unit_component(az, len));
         r.last     = (cx == GRID - 1 && cy == GRID - 1);
         // On a flat patch the normal must be (0, 0, 1) by inspection.
         if (flat && (r.normal_x != 0 || r.normal_y != 0 || r.normal_z != 15'd16384)) begin
            $error("flat normal: expected 0 0 16384, predicted %0d %0d %0d",
                   r.normal_x, r.normal_y, r.normal_z);
            failures++;
         end
         normal_expected.push_back(r);
      end
      // Line buffers trail the stream by two words.
      wi = (cx + GRID - 2) % GRID;
      line_above2[wi] = line_above[wi];
      line_above[wi]  = delay_line[1];
      delay_line[1]   = delay_line[0];
      delay_line[0]   = s.height;
      cx++;
      if (cx >= GRID) begin
         cx = 0;
         cy++;
         if (cy >= GRID) cy = 0;
      end
      col_pos = cx;
      row_pos = cy;
   endtask

   // Idle percentages per phase: sender busy-ish first, then receiver, then none.
   function automatic int send_idle_pct();
      if (taken < sample_q.size() / 3) return 24;
      if (taken < 2 * sample_q.size() / 3) return 85;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (taken < sample_q.size() / 3) return 85;
      if (taken < 2 * sample_q.size() / 3) return 24;
      return 0;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: stall at random, compare each word against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (normal_expected.size() == 0) begin
               $error("unexpected normal word at pos %0d,%0d", rsp_data.pos_x, rsp_data.pos_y);
               failures++;
            end else begin
               want = normal_expected.pop_front();
               if (rsp_data.pos_x !== want.pos_x) begin
                  $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_data.pos_x);
                  failures++;
               end
               if (rsp_data.pos_y !== want.pos_y) begin
                  $error("pos_y: expected %0d, got %0d", want.pos_y, rsp_data.pos_y);
                  failures++;
               end
               if (rsp_data.normal_x !== want.normal_x) begin
                  $error("normal_x: expected %0d, got %0d", want.normal_x, rsp_data.normal_x);
                  failures++;
               end
               if (rsp_data.normal_y !== want.normal_y) begin
                  $error("normal_y: expected %0d, got %0d", want.normal_y, rsp_data.normal_y);
                  failures++;
               end
               if (rsp_data.normal_z !== want.normal_z) begin
                  $error("normal_z: expected %0d, got %0d", want.normal_z, rsp_data.normal_z);
                  failures++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
   end

   initial begin
      logic [15:0] h;
      int          added;
      int          run_len;
      req_type     item;
      bit          done;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      failures  = 0;
      taken     = 0;
      col_pos   = 0;
      row_pos   = 0;
      delay_line[0] = '0;
      delay_line[1] = '0;
      foreach (line_above[i]) begin
         line_above[i]  = '0;
         line_above2[i] = '0;
      end

      // Directed rows. The opening rows fill two full lines after reset, so no
      // unwritten buffer entry is ever read.
      dir_rows = '{
         '{16'sd0,      1'b1, 130, 1'b1},   // flat zero surface from reset
         '{16'sd0,      1'b0, 60,  1'b1},
         '{16'sd32767,  1'b0, 64,  1'b0},   // step up: steepest rise
         '{-16'sd32768, 1'b0, 64,  1'b0},   // step down: steepest fall
         '{16'sd32767,  1'b0, 1,   1'b0},   // column swings: steepest slope in x
         '{16'sd0,      1'b0, 1,   1'b0},
         '{-16'sd32768, 1'b0, 1,   1'b0},
         '{16'sd0,      1'b0, 1,   1'b0},
         '{16'sd32767,  1'b0, 70,  1'b0},
         '{16'sd100,    1'b1, 150, 1'b0},   // frame start in mid grid
         '{16'sd5,      1'b1, 200, 1'b1},   // fresh flat grid
         '{-16'sd1,     1'b0, 40,  1'b0}
      };
      foreach (dir_rows[r]) begin
         for (int k = 0; k < dir_rows[r].count; k++) begin
            item.height      = dir_rows[r].height;
            item.frame_start = dir_rows[r].frame_start && (k == 0);
            sample_q.push_back(item);
            flat_q.push_back(dir_rows[r].flat);
         end
      end

      // Grids of random length, mostly long and cut short by the next frame start.
      h = '0;
      added = 0;
      while (added < RANDOM_WORDS) begin
         run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 300) : $urandom_range(130, 600);
         if (run_len > RANDOM_WORDS - added) run_len = RANDOM_WORDS - added;
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(7) == 0) h = 16'($urandom);
            else h = 16'(h + 16'($urandom_range(1024)) - 16'd512);
            item.height      = h;
            item.frame_start = (k == 0);
            sample_q.push_back(item);
            flat_q.push_back(1'b0);
         end
         added += run_len;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sender: take a word on a handshake, then offer the next one or idle.
      done = 0;
      while (!done) begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            accept_sample(req_data, flat_q[taken]);
            taken++;
         end
         if (!req_valid || req_ready) begin
            if (taken < sample_q.size() && $urandom_range(99) >= send_idle_pct()) begin
               req_valid <= 1'b1;
               req_data  <= sample_q[taken];
            end else begin
               req_valid <= 1'b0;
            end
         end
         done = (taken == sample_q.size());
      end

      while (normal_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
